### rtl/core/rgb_to_packed_yuv422_defines.svh
// assertion macros shared by the rgb to packed yuv 4:2:2 converter
`ifndef RGB_TO_PACKED_YUV422_DEFINES_SVH
`define RGB_TO_PACKED_YUV422_DEFINES_SVH

// same-cycle implication, checked on i_clk, off while i_rst_n is low
`define RGBYUV_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rgbyuv check failed");

// next-cycle implication, checked on i_clk, off while i_rst_n is low
`define RGBYUV_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rgbyuv check failed");

`endif

### rtl/core/rgbyuv_pkg.sv
// types, constants and pixel math for the rgb to packed yuv 4:2:2 converter
package rgbyuv_pkg;

    localparam int PIXEL_W = 32;
    localparam int WORD_W  = 32;
    localparam int C565_W  = 16;
    localparam int Q_SHIFT = 16;
    localparam int ACC_W   = 27;

    typedef logic signed [ACC_W-1:0] t_acc;
    typedef logic [PIXEL_W-1:0]      t_pixel;
    typedef logic [WORD_W-1:0]       t_word;
    typedef logic [C565_W-1:0]       t_c565;

    // register indexes
    localparam logic [0:0] REG_SOURCE_FORMAT = 1'b0;
    localparam logic [0:0] REG_BYTE_ORDER    = 1'b1;

    // register codes
    localparam logic FMT_RGB565   = 1'b0;
    localparam logic FMT_ARGB8888 = 1'b1;
    localparam logic ORDER_YUY2   = 1'b0;
    localparam logic ORDER_UYVY   = 1'b1;

    // bt.601 studio range, q16
    localparam t_acc KY_R = 27'sd16843;
    localparam t_acc KY_G = 27'sd33030;
    localparam t_acc KY_B = 27'sd6423;
    localparam t_acc KU_R = -27'sd9699;
    localparam t_acc KU_G = -27'sd19071;
    localparam t_acc KU_B = 27'sd28770;
    localparam t_acc KV_R = 27'sd28770;
    localparam t_acc KV_G = -27'sd24117;
    localparam t_acc KV_B = -27'sd4653;
    localparam t_acc Y_OFFSET = 27'sd1048576;  // 16 << 16
    localparam t_acc C_OFFSET = 27'sd8388608;  // 128 << 16

    localparam logic [15:0] MASK_R565 = 16'hf800;
    localparam logic [15:0] MASK_G565 = 16'h07e0;

    // argb8888 keeps the top 5/6/5 bits of r/g/b
    function automatic t_c565 to_c565(input logic fmt, input t_pixel p);
        t_c565 res;
        case (fmt)
            FMT_ARGB8888: res = (p[23:8] & MASK_R565) | (p[20:5] & MASK_G565)
                                | {11'd0, p[7:3]};
            default:      res = p[15:0];
        endcase
        return res;
    endfunction

    function automatic t_acc widen(input logic [7:0] ch);
        return $signed({{(ACC_W-8){1'b0}}, ch});
    endfunction

    function automatic t_acc mac3(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input t_acc kr,
                                  input t_acc kg, input t_acc kb, input t_acc off);
        return widen(r) * kr + widen(g) * kg + widen(b) * kb + off;
    endfunction

    function automatic logic [7:0] clamp_q16(input t_acc acc);
        logic [7:0] res;
        if (acc < 0) begin
            res = 8'd0;
        end else if (acc[ACC_W-2:Q_SHIFT+8] != '0) begin
            res = 8'hff;
        end else begin
            res = acc[Q_SHIFT+7:Q_SHIFT];
        end
        return res;
    endfunction

endpackage

### rtl/core/rgbyuv_ifs.sv
// valid/ready channels for source pixels and packed yuv words
interface rgbyuv_in_if import rgbyuv_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel pixel;
    logic   row_end;
    logic   frame_end;

    modport source(output valid, pixel, row_end, frame_end, input ready);
    modport sink(input valid, pixel, row_end, frame_end, output ready);
endinterface

interface rgbyuv_out_if import rgbyuv_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word packed_word;
    logic  row_end_out;
    logic  frame_end_out;

    modport source(output valid, packed_word, row_end_out, frame_end_out, input ready);
    modport sink(input valid, packed_word, row_end_out, frame_end_out, output ready);
endinterface

### rtl/core/rgb_to_packed_yuv422.sv
// top level: rgb565 / argb8888 pixel to one packed yuy2 or uyvy word
//
// Each source word on i_pix becomes one 32-bit 4:2:2 word on o_yuv holding
// Y twice plus U and V (2x horizontal output), with row_end and frame_end
// carried alongside. The pixel is first brought to rgb565 (argb8888 keeps the
// top 5/6/5 bits), each channel widened to 8 bits by bit replication, then
// converted with q16 bt.601 studio-range coefficients, truncated and clamped
// to 0..255. Throughput is one word per clock while neither side stalls;
// words pass the input register, the conversion math and the result
// register in turn. Either side may stall at any time; an empty input stage
// takes a word while a finished result waits. The user writes source_format
// (byte 0x0) and byte_order (byte 0x4) over the apb port only while the block
// is idle, which it does not enforce; only bit 0 of each counts and reads return the stored bit.
`include "rgb_to_packed_yuv422_defines.svh"

module rgb_to_packed_yuv422 import rgbyuv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rgbyuv_in_if.sink   i_pix,
    rgbyuv_out_if.source o_yuv,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic r_source_format;
    logic r_byte_order;

    // input stage: pixel already reduced to rgb565
    logic  r_s1_valid;
    t_c565 r_s1_c565;
    logic  r_s1_row_end;
    logic  r_s1_frame_end;
    t_c565 n_s1_c565;

    // result stage
    logic  r_out_valid;
    t_word r_out_word;
    logic  r_out_row_end;
    logic  r_out_frame_end;
    t_word n_out_word;

    logic       out_load;
    logic       s1_move;
    logic       in_accept;
    logic       cfg_write;
    logic [0:0] cfg_idx;

    logic [7:0] ch_r;
    logic [7:0] ch_g;
    logic [7:0] ch_b;
    logic [7:0] y_val;
    logic [7:0] u_val;
    logic [7:0] v_val;

    // ---------------- apb config ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[2:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_format <= FMT_RGB565;
            r_byte_order    <= ORDER_YUY2;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_SOURCE_FORMAT: r_source_format <= pwdata[0];
                REG_BYTE_ORDER:    r_byte_order    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_SOURCE_FORMAT: prdata = {31'd0, r_source_format};
            REG_BYTE_ORDER:    prdata = {31'd0, r_byte_order};
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    // result register frees up when empty or being taken; input stage moves
    // whenever it holds a word and the result register can load
    assign out_load    = !r_out_valid || o_yuv.ready;
    assign s1_move     = r_s1_valid && out_load;
    assign i_pix.ready = !r_s1_valid || out_load;
    assign in_accept   = i_pix.valid && i_pix.ready;

    // ---------------- input stage ----------------
    assign n_s1_c565 = to_c565(r_source_format, i_pix.pixel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_pix.ready) begin
            r_s1_valid <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_c565      <= n_s1_c565;
            r_s1_row_end   <= i_pix.row_end;
            r_s1_frame_end <= i_pix.frame_end;
        end
    end

    // ---------------- color conversion ----------------
    // bit replication to 8 bits per channel
    assign ch_r = {r_s1_c565[15:11], r_s1_c565[15:13]};
    assign ch_g = {r_s1_c565[10:5],  r_s1_c565[10:9]};
    assign ch_b = {r_s1_c565[4:0],   r_s1_c565[4:2]};

    assign y_val = clamp_q16(mac3(ch_r, ch_g, ch_b, KY_R, KY_G, KY_B, Y_OFFSET));
    assign u_val = clamp_q16(mac3(ch_r, ch_g, ch_b, KU_R, KU_G, KU_B, C_OFFSET));
    assign v_val = clamp_q16(mac3(ch_r, ch_g, ch_b, KV_R, KV_G, KV_B, C_OFFSET));

    // first byte in bits 7:0
    always_comb begin
        case (r_byte_order)
            ORDER_UYVY: n_out_word = {y_val, v_val, y_val, u_val};
            default:    n_out_word = {v_val, y_val, u_val, y_val};
        endcase
    end

    // ---------------- result stage ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_word      <= n_out_word;
            r_out_row_end   <= r_s1_row_end;
            r_out_frame_end <= r_s1_frame_end;
        end
    end

    assign o_yuv.valid         = r_out_valid;
    assign o_yuv.packed_word   = r_out_word;
    assign o_yuv.row_end_out   = r_out_row_end;
    assign o_yuv.frame_end_out = r_out_frame_end;

    // ---------------- checks ----------------
    // an accepted pixel lands in the input stage
    `RGBYUV_ASSERT_NXT(a_accept_fills_s1, in_accept, r_s1_valid)
    // a stalled input stage keeps its word when the result stays blocked
    `RGBYUV_ASSERT_NXT(a_s1_held, r_s1_valid && r_out_valid && !o_yuv.ready, r_s1_valid)
    // input back-pressure only when both stages are full
    `RGBYUV_ASSERT_IMP(a_ready_low_full, !i_pix.ready, r_s1_valid && r_out_valid)
    // every result word carries y twice in one of the two orders
    `RGBYUV_ASSERT_IMP(a_y_twice, r_out_valid,
        r_out_word[7:0] == r_out_word[23:16] || r_out_word[15:8] == r_out_word[31:24])

endmodule

### sim/rgb_to_packed_yuv422_tb.sv
`timescale 1ns / 1ps
// testbench for the rgb to packed yuv 4:2:2 converter: random pixels checked against a predictor
module rgb_to_packed_yuv422_tb import rgbyuv_pkg::*; ();

    // bt.601 studio range in q16, kept apart from the block's own constants
    localparam int CY_R = 16843;
    localparam int CY_G = 33030;
    localparam int CY_B = 6423;
    localparam int CU_R = 9699;
    localparam int CU_G = 19071;
    localparam int CU_B = 28770;
    localparam int CV_R = 28770;
    localparam int CV_G = 24117;
    localparam int CV_B = 4653;
    localparam int Y_BIAS = 16 << 16;
    localparam int C_BIAS = 128 << 16;

    localparam int MAX_REPORTS    = 10;
    localparam int LATENCY_CYCLES = 8;     // settling margin after the last predicted word
    localparam int STALL_LIMIT    = 2000;  // cycles with no word moving on either side
    localparam int HOLD_CYCLES    = 300;   // long output stall that backs the block up

    // one expected output word with its end flags
    typedef struct {
        t_word packed_word;
        logic  row_end;
        logic  frame_end;
    } t_yuv_word;

    // keeps the register copies, predicts each word and checks what comes out
    class t_yuv_scoreboard;
        logic      fmt;
        logic      order;
        t_yuv_word pending_words[$];
        int        errors;

        function new();
            fmt    = FMT_RGB565;
            order  = ORDER_YUY2;
            errors = 0;
        endfunction

        function void set_reg(logic [0:0] idx, logic [31:0] value);
            case (idx)
                REG_SOURCE_FORMAT: fmt = value[0];
                REG_BYTE_ORDER:    order = value[0];
                default:           ;
            endcase
        endfunction

        // truncate the q16 sum and saturate to one byte
        function logic [7:0] sat_byte(int acc);
            if (acc < 0) return 8'd0;
            if ((acc >>> 16) > 255) return 8'hff;
            return acc[23:16];
        endfunction

        function t_yuv_word pack_pixel(t_pixel p, logic re, logic fe);
            logic [15:0] c565;
            logic [7:0]  r8, g8, b8, y, u, v;
            int          r, g, b;
            t_yuv_word   res;
            if (fmt == FMT_ARGB8888) c565 = {p[23:19], p[15:10], p[7:3]};
            else c565 = p[15:0];
            // widen 5/6/5 to 8 bits by repeating the top bits
            r8 = {c565[15:11], c565[15:13]};
            g8 = {c565[10:5], c565[10:9]};
            b8 = {c565[4:0], c565[4:2]};
            r = r8;
            g = g8;
            b = b8;
            y = sat_byte(CY_R * r + CY_G * g + CY_B * b + Y_BIAS);
            u = sat_byte(-CU_R * r - CU_G * g + CU_B * b + C_BIAS);
            v = sat_byte(CV_R * r - CV_G * g - CV_B * b + C_BIAS);
            if (order == ORDER_UYVY) res.packed_word = {y, v, y, u};
            else res.packed_word = {v, y, u, y};
            res.row_end   = re;
            res.frame_end = fe;
            return res;
        endfunction

        function void note_pixel(t_pixel p, logic re, logic fe);
            pending_words.push_back(pack_pixel(p, re, fe));
        endfunction

        function void check_word(t_word w, logic re, logic fe);
            t_yuv_word want;
            if (pending_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected word %h re %b fe %b", w, re, fe);
                return;
            end
            want = pending_words.pop_front();
            if (w !== want.packed_word || re !== want.row_end || fe !== want.frame_end) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("word mismatch: expected %h re %b fe %b, got %h re %b fe %b",
                             want.packed_word, want.row_end, want.frame_end, w, re, fe);
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function int failures();
            return errors + pending_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rgbyuv_in_if  pix_if ();
    rgbyuv_out_if yuv_if ();

    t_yuv_scoreboard sb;

    // idle odds in percent per cycle, and the remaining forced output stall
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    rgb_to_packed_yuv422 DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_if.sink),
        .o_yuv   (yuv_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // output side: random ready, or held low while a long stall is counting down
    initial begin
        yuv_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                yuv_if.ready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                yuv_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // every word taken from the block is checked against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && yuv_if.valid && yuv_if.ready)
            sb.check_word(yuv_if.packed_word, yuv_if.row_end_out, yuv_if.frame_end_out);
    end

    // watchdog: gives up when neither side has moved a word for too long
    initial begin
        int stall_count;
        stall_count = 0;
        while (stall_count < STALL_LIMIT) begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (yuv_if.valid && yuv_if.ready))
                stall_count = 0;
            else
                stall_count = stall_count + 1;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // offer one pixel, with random idle cycles first, and return at the accepting edge
    task automatic send_pixel(input t_pixel p, input logic re, input logic fe);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.pixel     <= p;
        pix_if.row_end   <= re;
        pix_if.frame_end <= fe;
        do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
        sb.note_pixel(p, re, fe);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // wait for every predicted word, then let the pipeline settle
    task automatic drain();
        while (sb.pending() != 0) @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
    endtask

    // one setting of both registers, then a run of random pixels
    task automatic run_phase(input logic fmt, input logic order, input int sidle,
                             input int ridle, input int count, input int hold);
        drain();
        // junk in the upper bits must not matter
        write_reg(REG_SOURCE_FORMAT, ($urandom & 32'hffff_fffe) | {31'd0, fmt});
        write_reg(REG_BYTE_ORDER, ($urandom & 32'hffff_fffe) | {31'd0, order});
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        hold_left     = hold;
        for (int k = 0; k < count; k++)
            send_pixel($urandom, $urandom_range(7) == 0, $urandom_range(15) == 0);
        pix_if.valid <= 1'b0;
    endtask

    initial begin
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 55;
        hold_left     = 0;
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        pix_if.valid     <= 1'b0;
        pix_if.pixel     <= '0;
        pix_if.row_end   <= 1'b0;
        pix_if.frame_end <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setting: rgb565 in, yuy2 out
        send_pixel(32'h0000_0000, 1'b0, 1'b0);  // black
        send_pixel(32'h0000_ffff, 1'b1, 1'b0);  // white
        send_pixel(32'h0000_f800, 1'b0, 1'b1);  // pure red
        send_pixel(32'h0000_07e0, 1'b1, 1'b1);  // pure green
        send_pixel(32'h0000_001f, 1'b0, 1'b0);  // pure blue
        send_pixel(32'hffff_0000, 1'b0, 1'b0);  // upper half ignored, still black
        send_pixel(32'ha5a5_0821, 1'b0, 1'b0);  // lsb of each channel
        send_pixel(32'h0000_8410, 1'b1, 1'b0);  // msb of each channel
        pix_if.valid <= 1'b0;

        // argb8888 in, uyvy out, with upper bits set in both register writes
        drain();
        write_reg(REG_SOURCE_FORMAT, 32'hffff_ffff);
        write_reg(REG_BYTE_ORDER, 32'h0000_0003);
        send_pixel(32'h0000_0000, 1'b0, 1'b0);
        send_pixel(32'hffff_ffff, 1'b1, 1'b1);
        send_pixel(32'hff00_0000, 1'b0, 1'b0);  // alpha only, black
        send_pixel(32'h0007_0307, 1'b0, 1'b0);  // only dropped low bits, black
        send_pixel(32'h00ff_0000, 1'b0, 1'b0);
        send_pixel(32'h0000_ff00, 1'b0, 1'b0);
        send_pixel(32'h0000_00ff, 1'b0, 1'b0);
        send_pixel(32'h00f8_fcf8, 1'b1, 1'b0);  // just the kept bits, white
        send_pixel(32'h8012_3456, 1'b0, 1'b1);
        pix_if.valid <= 1'b0;

        // sender idles lightly, receiver heavily
        run_phase(FMT_RGB565,   ORDER_YUY2, 14, 55, 300, 0);
        run_phase(FMT_ARGB8888, ORDER_YUY2, 14, 55, 300, 0);
        // the other way round
        run_phase(FMT_ARGB8888, ORDER_UYVY, 55, 14, 300, 0);
        run_phase(FMT_RGB565,   ORDER_UYVY, 55, 14, 300, 0);
        // full rate, first with a long output stall so the input backs up
        run_phase(FMT_ARGB8888, ORDER_YUY2, 0, 0, 325, HOLD_CYCLES);
        run_phase(FMT_RGB565,   ORDER_YUY2, 0, 0, 300, 0);

        drain();
        if (sb.failures() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
